// File: rtl/mtslru_pkg.sv
// Shared constants, op codes and item types for the media track statistics block.
`default_nettype none

package mtslru_pkg;

    localparam int RECENT_DEPTH = 8;
    localparam int FILL_W       = $clog2(RECENT_DEPTH + 1);
    localparam int OP_W         = 3;
    localparam int GID_W        = 64;
    localparam int BYTE_W       = 32;
    localparam int CNT_W        = 48;

    // event kinds
    localparam logic [OP_W-1:0] OP_BEGIN_SUBGROUP = 3'd0;
    localparam logic [OP_W-1:0] OP_OBJECT_STREAM  = 3'd1;
    localparam logic [OP_W-1:0] OP_DATAGRAM       = 3'd2;
    localparam logic [OP_W-1:0] OP_SUBGROUP_OBJ   = 3'd3;
    localparam logic [OP_W-1:0] OP_PAYLOAD_CONT   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [GID_W-1:0]  group_id;
        logic [BYTE_W-1:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic             new_group;
        logic [CNT_W-1:0] group_total;
        logic [CNT_W-1:0] subgroup_total;
        logic [CNT_W-1:0] object_total;
        logic [CNT_W-1:0] datagram_total;
        logic [CNT_W-1:0] byte_total;
    } out_item_t;

    // link between neighboring list cells: match seen so far, and the entry handed on
    typedef struct packed {
        logic             hit;
        logic [GID_W-1:0] entry;
    } cell_link_t;

    typedef struct packed {
        logic [CNT_W-1:0] groups;
        logic [CNT_W-1:0] subgroups;
        logic [CNT_W-1:0] objects;
        logic [CNT_W-1:0] datagrams;
        logic [CNT_W-1:0] bytes;
    } cnt_bank_t;

endpackage

`default_nettype wire

// File: rtl/mtslru_cell.sv
// One entry of the recent group list: compare against the key, shift in from the left neighbor.
`default_nettype none

module mtslru_cell
    import mtslru_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             step_i,
    input  wire logic             cmp_en_i,
    input  wire logic [GID_W-1:0] key_i,
    input  wire cell_link_t       prev_i,
    output cell_link_t            next_o
);

    logic [GID_W-1:0] entry_reg;
    logic [GID_W-1:0] entry_next;
    logic             match;

    assign match = cmp_en_i && (entry_reg == key_i);

    // a hit further left stops the shift here; a hit in this cell still takes the left entry
    always_comb begin
        entry_next = entry_reg;
        if (step_i && !prev_i.hit) begin
            entry_next = prev_i.entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign next_o.hit   = prev_i.hit | match;
    assign next_o.entry = entry_reg;

endmodule

`default_nettype wire

// File: rtl/mtslru_counters.sv
// Wrapping 48-bit traffic counters, bumped per event kind.
`default_nettype none

module mtslru_counters
    import mtslru_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept_i,
    input  wire logic [OP_W-1:0]   op_i,
    input  wire logic              group_new_i,
    input  wire logic [BYTE_W-1:0] byte_count_i,
    output cnt_bank_t              cnt_o
);

    cnt_bank_t cnt_reg;
    cnt_bank_t cnt_next;
    logic      inc_sub;
    logic      inc_obj;
    logic      inc_dg;
    logic      add_bytes;

    always_comb begin
        inc_sub   = 1'b0;
        inc_obj   = 1'b0;
        inc_dg    = 1'b0;
        add_bytes = 1'b0;
        case (op_i)
            OP_BEGIN_SUBGROUP: begin
                inc_sub = 1'b1;
            end
            OP_OBJECT_STREAM: begin
                inc_sub   = 1'b1;
                inc_obj   = 1'b1;
                add_bytes = 1'b1;
            end
            OP_DATAGRAM: begin
                inc_dg    = 1'b1;
                inc_obj   = 1'b1;
                add_bytes = 1'b1;
            end
            OP_SUBGROUP_OBJ: begin
                inc_obj   = 1'b1;
                add_bytes = 1'b1;
            end
            OP_PAYLOAD_CONT: begin
                add_bytes = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (accept_i) begin
            cnt_next.groups    = cnt_reg.groups    + CNT_W'(group_new_i);
            cnt_next.subgroups = cnt_reg.subgroups + CNT_W'(inc_sub);
            cnt_next.objects   = cnt_reg.objects   + CNT_W'(inc_obj);
            cnt_next.datagrams = cnt_reg.datagrams + CNT_W'(inc_dg);
            if (add_bytes) begin
                cnt_next.bytes = cnt_reg.bytes + CNT_W'(byte_count_i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt_o = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/media_track_stats_lru_counter.sv
// Top level: media track traffic statistics with a most-recently-used group list.
`default_nettype none

// Counts the events of one media track and returns one result item per input
// item: a new_group flag and the five running totals after that event.
// Throughput is one item per clock while m_ready is high. An accepted item is
// looked up and applied in the cycle it is accepted: the group id is broadcast
// to a row of RECENT_DEPTH list cells that compare in parallel, the hit flag
// ripples through the row so the lowest match wins, and on the same edge every
// cell left of (and including) the hit, or all cells on a miss, takes its left
// neighbor's entry while cell 0 loads the group id. m_valid is registered and
// rises in the cycle after acceptance. The counter registers themselves form
// the result payload, so the input is taken whenever the result slot is empty
// or is being taken in the same cycle. Only the first fill-count entries take
// part in the compare; list entries need no clearing after reset. direction is
// stored as a bank label and does not change any count.

module media_track_stats_lru_counter
    import mtslru_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    // configuration
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    // event input
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    // result output
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic              direction_reg;
    logic              m_valid_reg;
    logic              new_group_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              accept;
    logic              grp_event;
    logic              step;
    logic              group_new;
    cnt_bank_t         cnt;
    cell_link_t        links [RECENT_DEPTH+1];

    // bank label only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            direction_reg <= cfg_wr_data;
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // group-bearing kinds
    always_comb begin
        case (s_data.op) inside
            OP_BEGIN_SUBGROUP, OP_OBJECT_STREAM, OP_DATAGRAM: grp_event = 1'b1;
            default:                                         grp_event = 1'b0;
        endcase
    end

    assign step = accept && grp_event;

    // cell row; left end injects the key with no hit yet
    assign links[0].hit   = 1'b0;
    assign links[0].entry = s_data.group_id;

    for (genvar i = 0; i < RECENT_DEPTH; i++) begin : g_cell
        mtslru_cell u_cell (
            .aclk     (aclk),
            .step_i   (step),
            .cmp_en_i (fill_reg > FILL_W'(i)),
            .key_i    (s_data.group_id),
            .prev_i   (links[i]),
            .next_o   (links[i+1])
        );
    end

    assign group_new = step && !links[RECENT_DEPTH].hit;

    // fill count saturates at the list depth
    always_comb begin
        fill_next = fill_reg;
        if (group_new && (fill_reg != FILL_W'(RECENT_DEPTH))) begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            new_group_reg <= group_new;
        end
    end

    mtslru_counters u_counters (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept_i     (accept),
        .op_i         (s_data.op),
        .group_new_i  (group_new),
        .byte_count_i (s_data.byte_count),
        .cnt_o        (cnt)
    );

    // counters only move on acceptance, which is also when the result slot reloads
    assign m_valid                = m_valid_reg;
    assign m_data.new_group       = new_group_reg;
    assign m_data.group_total     = cnt.groups;
    assign m_data.subgroup_total  = cnt.subgroups;
    assign m_data.object_total    = cnt.objects;
    assign m_data.datagram_total  = cnt.datagrams;
    assign m_data.byte_total      = cnt.bytes;

endmodule

`default_nettype wire

// File: rtl/mtslru_checker.sv
// Port-level checks for the media track statistics block, bound to the top level.
`default_nettype none

module mtslru_checker
    import mtslru_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      cfg_wr_en,
    input wire logic      cfg_wr_data,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    logic s_acc;
    logic no_grp;

    assign s_acc  = aresetn && s_valid && s_ready;
    assign no_grp = !((s_data.op == OP_BEGIN_SUBGROUP) || (s_data.op == OP_OBJECT_STREAM) ||
                      (s_data.op == OP_DATAGRAM));

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // every accepted item yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_valid)
        else $error("accepted item gave no result");

    // events without a group never report a new group
    a_no_grp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && no_grp |=> !m_data.new_group)
        else $error("new_group set for an event without a group");

    // new_group flag agrees with the group counter moving
    a_grp_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_data.new_group == (m_data.group_total != $past(m_data.group_total)))
        else $error("new_group and group_total disagree");

    // subgroup object events leave the subgroup count alone
    a_sub_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_data.op == OP_SUBGROUP_OBJ)
        |=> m_data.subgroup_total == $past(m_data.subgroup_total))
        else $error("subgroup_total moved on a subgroup object event");

endmodule

bind media_track_stats_lru_counter mtslru_checker u_mtslru_checker (.*);

`default_nettype wire
